// File: rtl/prq_pkg.sv
// Shared constants and operation codes for the priority ready-queue scheduler.
package prq_pkg;

   localparam int DEF_NUM_LEVELS = 8;
   localparam int DEF_NUM_TASKS  = 16;
   localparam int FUNC_W         = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQUEUE = 2'd0,
      FUNC_DEQUEUE = 2'd1,
      FUNC_SELECT  = 2'd2
   } func_type;

endpackage

// File: rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler: per-level FIFO task queues with a ready bitmap.
//
// Usage:
//   Commands arrive on the req_ channel and are taken at a rising edge with
//   start high and busy low; busy stays low, so a command may be issued in
//   every cycle. req_func selects enqueue, dequeue or select.
//   Each command yields exactly one response beat on the rsp_ channel, shown
//   for a single cycle with rsp_valid high. The response beat passes through
//   the command register and then the response register. Throughput is one
//   command per cycle, set by the single read port of the link RAM, whose read
//   address is issued from the command port in the cycle before its use.
//   Commands see the state left by every earlier command, back to back.
//   Reset clears the ready bitmap (every queue empty) and the pipeline valid
//   flags; queue head, tail and link tables are not cleared and are only
//   read after being written. There is no clearing pass.
//   The receiver cannot stall: each response beat is taken in the cycle it is
//   shown.
module priority_ready_queue_scheduler #(
   parameter int NUM_LEVELS = prq_pkg::DEF_NUM_LEVELS,
   parameter int NUM_TASKS  = prq_pkg::DEF_NUM_TASKS,
   localparam int LVL_W  = $clog2(NUM_LEVELS),
   localparam int TASK_W = $clog2(NUM_TASKS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [prq_pkg::FUNC_W-1:0] req_func,
   input  logic [TASK_W-1:0]         req_task_id,
   input  logic [LVL_W-1:0]          req_priority_req,
   output logic                      rsp_valid,
   output logic [TASK_W-1:0]         rsp_result_task,
   output logic                      rsp_found,
   output logic [LVL_W-1:0]          rsp_ready_priority
);

   import prq_pkg::*;

   logic                  s1_valid_ff;
   func_type              s1_func_ff;
   logic [TASK_W-1:0]     s1_task_ff;
   logic [LVL_W-1:0]      s1_prio_ff;
   logic [TASK_W-1:0]     s1_head_ff;

   logic [TASK_W-1:0]     head_ff [NUM_LEVELS];
   logic [TASK_W-1:0]     head_in [NUM_LEVELS];
   logic [TASK_W-1:0]     tail_ff [NUM_LEVELS];
   logic [TASK_W-1:0]     tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] ready_ff;
   logic [NUM_LEVELS-1:0] ready_in;
   logic [NUM_TASKS-1:0]  link_clr_ff;
   logic [NUM_TASKS-1:0]  link_clr_in;

   logic                  link_we;
   logic [TASK_W-1:0]     link_waddr;
   logic [TASK_W-1:0]     link_raddr;
   logic [TASK_W-1:0]     link_q;
   logic                  byp_hit_ff;
   logic [TASK_W-1:0]     byp_data_ff;
   logic [TASK_W-1:0]     next_link;

   logic                  rsp_valid_ff;
   logic [TASK_W-1:0]     rsp_task_ff;
   logic                  rsp_found_ff;
   logic [LVL_W-1:0]      rsp_prio_ff;
   logic [TASK_W-1:0]     rsp_task_in;
   logic                  rsp_found_in;
   logic [LVL_W-1:0]      rsp_prio_in;

   logic                  lvl_ok;
   logic                  task_ok;
   logic [LVL_W-1:0]      prio_idx;
   logic [LVL_W-1:0]      req_prio_idx;
   logic [NUM_LEVELS-1:0] pbit;
   logic                  rdy;
   logic [TASK_W-1:0]     tail_p;
   logic                  enq;
   logic                  deq;
   logic                  sel;
   logic                  deq_last;
   logic [NUM_LEVELS-1:0] lowest;
   logic [LVL_W-1:0]      sel_idx;

   assign busy = 1'b0;

   assign lvl_ok   = int'(s1_prio_ff) < NUM_LEVELS;
   assign task_ok  = int'(s1_task_ff) < NUM_TASKS;
   assign prio_idx = lvl_ok ? s1_prio_ff : '0;
   assign tail_p   = tail_ff[prio_idx];

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         pbit[i] = lvl_ok && (s1_prio_ff == LVL_W'(i));
      end
   end

   assign rdy      = |(ready_ff & pbit);
   assign enq      = s1_valid_ff && (s1_func_ff == FUNC_ENQUEUE) && lvl_ok && task_ok;
   assign deq      = s1_valid_ff && (s1_func_ff == FUNC_DEQUEUE) && rdy;
   assign sel      = s1_valid_ff && (s1_func_ff == FUNC_SELECT);
   assign deq_last = s1_head_ff == tail_p;

   assign next_link = link_clr_ff[s1_head_ff] ? '0 : (byp_hit_ff ? byp_data_ff : link_q);

   // isolate the highest-priority ready level
   assign lowest = ready_ff & (~ready_ff + NUM_LEVELS'(1));

   always_comb begin
      sel_idx = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (lowest[i]) begin
            sel_idx = sel_idx | LVL_W'(i);
         end
      end
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      ready_in    = ready_ff;
      link_clr_in = link_clr_ff;
      link_we     = 1'b0;
      link_waddr  = tail_p;
      if (enq) begin
         tail_in[prio_idx] = s1_task_ff;
         if (!rdy) begin
            head_in[prio_idx] = s1_task_ff;
            ready_in          = ready_ff | pbit;
         end else begin
            link_we                 = 1'b1;
            link_clr_in[tail_p]     = 1'b0;
         end
         link_clr_in[s1_task_ff] = 1'b1;
      end
      if (deq) begin
         if (deq_last) begin
            ready_in = ready_ff & ~pbit;
         end else begin
            head_in[prio_idx] = next_link;
         end
      end
   end

   always_comb begin
      rsp_task_in  = '0;
      rsp_found_in = 1'b0;
      rsp_prio_in  = '0;
      if (deq) begin
         rsp_task_in  = s1_head_ff;
         rsp_found_in = 1'b1;
      end
      if (sel) begin
         rsp_found_in = |ready_ff;
         rsp_prio_in  = sel_idx;
      end
   end

   // prefetch the link of the head this command will see
   assign req_prio_idx = (int'(req_priority_req) < NUM_LEVELS) ? req_priority_req : '0;
   assign link_raddr   = head_in[req_prio_idx];

   prq_ram #(
      .WIDTH (TASK_W),
      .DEPTH (NUM_TASKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (s1_task_ff),
      .rd_addr (link_raddr),
      .rd_data (link_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         ready_ff     <= '0;
         byp_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         ready_ff     <= ready_in;
         byp_hit_ff   <= link_we && (link_waddr == link_raddr);
         rsp_valid_ff <= s1_valid_ff;
      end
      s1_func_ff  <= func_type'(req_func);
      s1_task_ff  <= req_task_id;
      s1_prio_ff  <= req_priority_req;
      s1_head_ff  <= link_raddr;
      byp_data_ff <= s1_task_ff;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      link_clr_ff <= link_clr_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_found_ff <= rsp_found_in;
      rsp_prio_ff  <= rsp_prio_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_task    = rsp_task_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_ready_priority = rsp_prio_ff;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("command beat produced no response beat");

   a_enq_marks_ready: assert property (@(posedge clock) disable iff (reset)
      enq |=> ready_ff[$past(prio_idx)])
      else $error("enqueue left its level not ready");

   a_last_deq_drains: assert property (@(posedge clock) disable iff (reset)
      deq && deq_last |=> !ready_ff[$past(prio_idx)])
      else $error("dequeue of last task left level ready");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_result_task == '0) && (rsp_ready_priority == '0))
      else $error("response without a find carries non-zero fields");

endmodule

// File: tb/sv/priority_ready_queue_scheduler_test.sv
// Self-checking testbench for the priority ready-queue scheduler: directed and random traffic.
module priority_ready_queue_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import prq_pkg::*;

   localparam int LEVELS         = DEF_NUM_LEVELS;
   localparam int TASKS          = DEF_NUM_TASKS;
   localparam int LVL_W          = $clog2(LEVELS);
   localparam int TASK_W         = $clog2(TASKS);
   localparam logic [FUNC_W-1:0] FUNC_UNDEFINED = 2'd3;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BEATS   = 1700;

   typedef struct packed {
      logic [TASK_W-1:0] task_out;
      logic              hit;
      logic [LVL_W-1:0]  level;
   } sched_outcome_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func         = '0;
   logic [TASK_W-1:0]   req_task_id      = '0;
   logic [LVL_W-1:0]    req_priority_req = '0;
   logic                rsp_valid;
   logic [TASK_W-1:0]   rsp_result_task;
   logic                rsp_found;
   logic [LVL_W-1:0]    rsp_ready_priority;

   logic [TASK_W-1:0]   level_head [LEVELS];
   logic [TASK_W-1:0]   level_tail [LEVELS];
   logic [TASK_W-1:0]   task_link [TASKS];
   logic [LEVELS-1:0]   level_ready  = '0;
   logic [TASKS-1:0]    queued_tasks = '0;

   sched_outcome_type   expected_outcomes [$];
   int                  mismatch_count = 0;
   int                  stalled_cycles = 0;

   priority_ready_queue_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_task_id        (req_task_id),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_result_task    (rsp_result_task),
      .rsp_found          (rsp_found),
      .rsp_ready_priority (rsp_ready_priority)
   );

   always #4 clock = ~clock;

   initial begin
      for (int p = 0; p < LEVELS; p++) begin
         level_head[p] = '0;
         level_tail[p] = '0;
      end
      for (int t = 0; t < TASKS; t++) begin
         task_link[t] = '0;
      end
   end

   task automatic apply_command(input logic [FUNC_W-1:0] func, input logic [TASK_W-1:0] tid,
                                input logic [LVL_W-1:0] prio, output sched_outcome_type outcome);
      outcome = '0;
      case (func)
         FUNC_ENQUEUE: begin
            if (!level_ready[prio]) begin
               level_head[prio]  = tid;
               level_tail[prio]  = tid;
               task_link[tid]    = '0;
               level_ready[prio] = 1'b1;
            end else begin
               task_link[level_tail[prio]] = tid;
               task_link[tid]              = '0;
               level_tail[prio]            = tid;
            end
            queued_tasks[tid] = 1'b1;
         end
         FUNC_DEQUEUE: begin
            if (level_ready[prio]) begin
               outcome.hit      = 1'b1;
               outcome.task_out = level_head[prio];
               if (level_head[prio] == level_tail[prio]) begin
                  level_ready[prio] = 1'b0;
               end else begin
                  level_head[prio] = task_link[level_head[prio]];
               end
               queued_tasks[outcome.task_out] = 1'b0;
            end
         end
         FUNC_SELECT: begin
            for (int p = 0; p < LEVELS && !outcome.hit; p++) begin
               if (level_ready[p]) begin
                  outcome.hit   = 1'b1;
                  outcome.level = LVL_W'(p);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [TASK_W-1:0] tid,
                            input logic [LVL_W-1:0] prio);
      sched_outcome_type outcome;
      @(negedge clock);
      start            <= 1'b1;
      req_func         <= func;
      req_task_id      <= tid;
      req_priority_req <= prio;
      do @(posedge clock); while (busy);
      apply_command(func, tid, prio, outcome);
      expected_outcomes.push_back(outcome);
   endtask

   task automatic pause_cycles(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start            <= 1'b0;
         req_func         <= FUNC_W'($urandom);
         req_task_id      <= TASK_W'($urandom);
         req_priority_req <= LVL_W'($urandom);
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain_beats();
      @(negedge clock);
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [TASK_W-1:0] pick_free_task();
      logic [TASK_W-1:0] tid;
      tid = TASK_W'($urandom);
      if (queued_tasks != '1) begin
         while (queued_tasks[tid]) tid = TASK_W'($urandom);
      end
      return tid;
   endfunction

   function automatic logic [LVL_W-1:0] pick_ready_level(input int top);
      logic [LVL_W-1:0] prio;
      prio = LVL_W'($urandom_range(0, top));
      if (level_ready != '0) begin
         while (!level_ready[prio]) prio = LVL_W'($urandom);
      end
      return prio;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_beats
      sched_outcome_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unrequested beat, task", rsp_result_task, -1);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_result_task !== want.task_out)
               report_mismatch("result_task", rsp_result_task, want.task_out);
            if (rsp_found !== want.hit)
               report_mismatch("found", rsp_found, want.hit);
            if (rsp_ready_priority !== want.level)
               report_mismatch("ready_priority", rsp_ready_priority, want.level);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_empty_queues();
      send_beat(FUNC_SELECT, '0, '0);
      send_beat(FUNC_DEQUEUE, '1, '0);
      send_beat(FUNC_DEQUEUE, '0, '1);
   endtask

   task automatic test_fifo_order();
      send_beat(FUNC_ENQUEUE, 4'd15, 3'd7);
      send_beat(FUNC_ENQUEUE, 4'd0, 3'd7);
      send_beat(FUNC_ENQUEUE, 4'd9, 3'd7);
      send_beat(FUNC_SELECT, '0, '0);
      repeat (4) send_beat(FUNC_DEQUEUE, '0, 3'd7);
   endtask

   task automatic test_select_priority();
      send_beat(FUNC_ENQUEUE, 4'd5, 3'd3);
      send_beat(FUNC_ENQUEUE, 4'd10, 3'd0);
      send_beat(FUNC_SELECT, '1, '1);
      send_beat(FUNC_DEQUEUE, '0, 3'd0);
      send_beat(FUNC_SELECT, '0, '0);
      send_beat(FUNC_DEQUEUE, '0, 3'd3);
   endtask

   task automatic test_undefined_func();
      send_beat(FUNC_UNDEFINED, '1, '1);
      send_beat(FUNC_SELECT, '0, '0);
   endtask

   task automatic test_requeue_task();
      send_beat(FUNC_ENQUEUE, 4'd4, 3'd2);
      send_beat(FUNC_ENQUEUE, 4'd4, 3'd2);
      send_beat(FUNC_DEQUEUE, '0, 3'd2);
      send_beat(FUNC_DEQUEUE, '0, 3'd2);
   endtask

   task automatic test_random_traffic();
      int               enqueue_pct [4] = '{70, 35, 55, 50};
      int               level_top [4]   = '{7, 1, 7, 3};
      int               r;
      bit               burst;
      logic [TASK_W-1:0] tid;
      logic [LVL_W-1:0]  prio;
      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < RANDOM_BEATS / 4; n++) begin
            if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            if (!burst) pause_cycles(random_gap());
            r = $urandom_range(0, 99);
            if (r < 2) begin
               send_beat(FUNC_UNDEFINED, TASK_W'($urandom), LVL_W'($urandom));
            end else if (r < enqueue_pct[phase]) begin
               tid  = ($urandom_range(0, 9) == 0) ? TASK_W'($urandom) : pick_free_task();
               prio = LVL_W'($urandom_range(0, level_top[phase]));
               send_beat(FUNC_ENQUEUE, tid, prio);
            end else if (r < enqueue_pct[phase] + (100 - enqueue_pct[phase]) * 3 / 4) begin
               prio = ($urandom_range(0, 4) == 0) ? LVL_W'($urandom)
                                                  : pick_ready_level(level_top[phase]);
               send_beat(FUNC_DEQUEUE, TASK_W'($urandom), prio);
            end else begin
               send_beat(FUNC_SELECT, TASK_W'($urandom), LVL_W'($urandom));
            end
         end
         drain_beats();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_empty_queues();
      test_fifo_order();
      test_select_priority();
      test_undefined_func();
      test_requeue_task();
      drain_beats();
      test_random_traffic();
      @(negedge clock);
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: priority_ready_queue_scheduler.f
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/priority_ready_queue_scheduler.sv
tb/sv/priority_ready_queue_scheduler_test.sv
